// File: hdl/multi_channel_motor_slew_limiter_top_assert.svh
`ifndef MULTI_CHANNEL_MOTOR_SLEW_LIMITER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_MOTOR_SLEW_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MCSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcsl check failed: same-cycle rule");

// Next-cycle implication.
`define MCSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcsl check failed: next-cycle rule");

`endif

// File: hdl/mcsl_pkg.sv
`timescale 1ns / 1ps

package mcsl_pkg;

  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_SET_SPEED     = 3'd1,
    CMD_SET_SPEED_NOW = 3'd2,
    CMD_SET_SLEW      = 3'd3,
    CMD_ADD_SLAVE     = 3'd4,
    CMD_KILL_ALL      = 3'd5
  } cmd_t;

  localparam logic signed [7:0] SPEED_MAX  = 8'sd127;
  localparam logic signed [7:0] SPEED_MIN  = -8'sd127;
  localparam logic        [6:0] SLEW_MAX   = 7'd127;
  localparam logic        [6:0] SLEW_RESET = 7'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic kill;
    logic add;
    logic tick_step;
    logic spr_init;
    logic spr_pick;
    logic spr_read;
    logic spr_mark;
  } mcsl_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       ch_ok;
    logic       tick_last;
    logic       out_free;
    logic       pending_any;
    logic       k_more;
  } mcsl_stat_t;

endpackage

// File: hdl/mcsl_if.sv
`timescale 1ns / 1ps

interface mcsl_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [3:0]         channel;
  logic signed [15:0] value;

  modport source (output valid, output cmd, output channel, output value, input ready);
  modport sink   (input valid, input cmd, input channel, input value, output ready);
endinterface

interface mcsl_drv_if;
  logic              valid;
  logic              ready;
  logic [3:0]        out_channel;
  logic signed [7:0] drive_level;
  logic              last;

  modport source (output valid, output out_channel, output drive_level, output last,
                  input ready);
  modport sink   (input valid, input out_channel, input drive_level, input last,
                  output ready);
endinterface

// File: hdl/multi_channel_motor_slew_limiter_top.sv
`timescale 1ns / 1ps

// Slew-rate limiter for NUM_CHANNELS motor channels. Each command beat is taken
// one at a time: a tick steps a single shared slew unit across the channels,
// pausing whenever the result register is still held by the sink; its
// NUM_CHANNELS result beats come out in channel order with last on the final
// one. Set speed, set speed immediate and set slew walk the slave graph from
// the addressed channel, reading each slave entry through the single read port
// of the slave-list memory. Add slave, kill all, commands to a channel out of
// range and unused codes finish in the dispatch state. No clearing pass follows
// reset.
module multi_channel_motor_slew_limiter_top #(
  parameter int NUM_CHANNELS = 10,
  parameter int MAX_SLAVES   = 5
) (
  input logic       clk,
  input logic       rst_n,
  mcsl_cmd_if.sink  in_ch,
  mcsl_drv_if.source out_ch
);
  import mcsl_pkg::*;

  mcsl_ctrl_t ctrl;
  mcsl_stat_t stat;

  mcsl_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mcsl_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_SLAVES   (MAX_SLAVES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_channel      (in_ch.channel),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_channel     (out_ch.out_channel),
    .out_drive_level (out_ch.drive_level),
    .out_last        (out_ch.last)
  );

endmodule

// File: hdl/mcsl_datapath.sv
`timescale 1ns / 1ps

module mcsl_datapath #(
  parameter int NUM_CHANNELS = 10,
  parameter int MAX_SLAVES   = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcsl_pkg::mcsl_ctrl_t ctrl,
  output mcsl_pkg::mcsl_stat_t stat,
  input  logic [2:0]         in_cmd,
  input  logic [3:0]         in_channel,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel,
  output logic signed [7:0]  out_drive_level,
  output logic               out_last
);
  import mcsl_pkg::*;

  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int KW    = $clog2(MAX_SLAVES + 1);
  localparam int DEPTH = NUM_CHANNELS * MAX_SLAVES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0]    NCH5    = 5'(NUM_CHANNELS);
  localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);
  localparam logic [KW-1:0] KMAX    = KW'(MAX_SLAVES);

  // latched item
  logic [2:0]         cmd_r;
  logic [3:0]         ch_r;
  logic signed [15:0] val_r;

  // per-channel state
  logic signed [7:0] target_r [NUM_CHANNELS];
  logic signed [7:0] drive_r  [NUM_CHANNELS];
  logic        [6:0] slew_r   [NUM_CHANNELS];
  logic     [KW-1:0] cnt_r    [NUM_CHANNELS];

  // slave lists, flat by channel
  logic [CW-1:0] slave_mem [DEPTH];
  logic [CW-1:0] rd_r;

  // walk state
  logic [NUM_CHANNELS-1:0] visited_r, pending_r;
  logic [CW-1:0]           cur_r;
  logic [KW-1:0]           k_r;
  logic [CW-1:0]           idx_r;

  logic                    out_valid_r;
  logic [3:0]              out_ch_r;
  logic signed [7:0]       out_drv_r;
  logic                    out_last_r;

  logic [CW-1:0]           ch_idx;
  logic                    ch_ok;
  logic                    add_ok;
  logic [AW-1:0]           add_addr, rd_addr;
  logic [NUM_CHANNELS-1:0] start_mask;
  logic [CW-1:0]           pick;
  logic signed [7:0]       spd_val;
  logic signed [16:0]      vx, mag;
  logic [6:0]              slew_val;
  logic signed [8:0]       dx, tx, sx, diff, nd;
  logic signed [7:0]       new_drive;

  assign ch_idx = ch_r[CW-1:0];
  assign ch_ok  = {1'b0, ch_r} < NCH5;
  assign add_ok = ch_ok && !val_r[15] && (val_r[14:0] < 15'(NUM_CHANNELS))
                  && (cnt_r[ch_idx] < KMAX);
  assign add_addr = AW'(int'(ch_idx) * MAX_SLAVES + int'(cnt_r[ch_idx]));
  assign rd_addr  = AW'(int'(cur_r) * MAX_SLAVES + int'(k_r));

  always_comb begin
    start_mask = '0;
    start_mask[ch_idx] = 1'b1;
  end

  // lowest pending channel
  always_comb begin
    pick = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pending_r[i]) pick = CW'(i);
    end
  end

  // setting values
  always_comb begin
    if (val_r > 16'(SPEED_MAX)) begin
      spd_val = SPEED_MAX;
    end else if (val_r < 16'(SPEED_MIN)) begin
      spd_val = SPEED_MIN;
    end else begin
      spd_val = val_r[7:0];
    end
    vx  = 17'(val_r);
    mag = vx[16] ? -vx : vx;
    slew_val = (mag > 17'(SLEW_MAX)) ? SLEW_MAX : mag[6:0];
  end

  // one slew step for the channel under the tick counter
  always_comb begin
    dx   = 9'(drive_r[idx_r]);
    tx   = 9'(target_r[idx_r]);
    sx   = {2'b00, slew_r[idx_r]};
    diff = (dx > tx) ? (dx - tx) : (tx - dx);
    if (diff > sx) begin
      nd = (dx < tx) ? (dx + sx) : (dx - sx);
    end else begin
      nd = tx;
    end
    new_drive = nd[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_item) begin
      cmd_r <= in_cmd;
      ch_r  <= in_channel;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        target_r[i] <= '0;
        drive_r[i]  <= '0;
        slew_r[i]   <= SLEW_RESET;
        cnt_r[i]    <= '0;
      end
    end else begin
      if (ctrl.kill) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          target_r[i] <= '0;
          drive_r[i]  <= '0;
        end
      end
      if (ctrl.add && add_ok) cnt_r[ch_idx] <= cnt_r[ch_idx] + 1'b1;
      if (ctrl.tick_step) drive_r[idx_r] <= new_drive;
      if (ctrl.spr_pick) begin
        if (cmd_r == CMD_SET_SLEW) begin
          slew_r[pick] <= slew_val;
        end else begin
          target_r[pick] <= spd_val;
          if (cmd_r == CMD_SET_SPEED_NOW) drive_r[pick] <= spd_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add && add_ok) slave_mem[add_addr] <= val_r[CW-1:0];
    if (ctrl.spr_read) rd_r <= slave_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      pending_r <= '0;
      cur_r     <= '0;
      k_r       <= '0;
      idx_r     <= '0;
    end else begin
      if (ctrl.ld_item) idx_r <= '0;
      if (ctrl.tick_step) idx_r <= idx_r + 1'b1;
      if (ctrl.spr_init) begin
        visited_r <= start_mask;
        pending_r <= start_mask;
      end
      if (ctrl.spr_pick) begin
        pending_r[pick] <= 1'b0;
        cur_r <= pick;
        k_r   <= '0;
      end
      if (ctrl.spr_read) k_r <= k_r + 1'b1;
      // first visit queues the slave; a repeat is dropped
      if (ctrl.spr_mark && !visited_r[rd_r]) begin
        visited_r[rd_r] <= 1'b1;
        pending_r[rd_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.tick_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick_step) begin
      out_ch_r   <= 4'(idx_r);
      out_drv_r  <= new_drive;
      out_last_r <= (idx_r == LAST_CH);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_drive_level = out_drv_r;
  assign out_last        = out_last_r;

  assign stat.cmd         = cmd_r;
  assign stat.ch_ok       = ch_ok;
  assign stat.tick_last   = (idx_r == LAST_CH);
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.pending_any = |pending_r;
  assign stat.k_more      = k_r < cnt_r[cur_r];

endmodule

// File: hdl/mcsl_controller.sv
`timescale 1ns / 1ps

module mcsl_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcsl_pkg::mcsl_stat_t stat,
  output mcsl_pkg::mcsl_ctrl_t ctrl
);
  import mcsl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_TICK     = 6'b000100,
    ST_PICK     = 6'b001000,
    ST_READ     = 6'b010000,
    ST_MARK     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.ld_item = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        unique case (stat.cmd) inside
          CMD_TICK: state_nxt = ST_TICK;
          CMD_KILL_ALL: ctrl.kill = 1'b1;
          CMD_SET_SPEED, CMD_SET_SPEED_NOW, CMD_SET_SLEW: begin
            if (stat.ch_ok) begin
              ctrl.spr_init = 1'b1;
              state_nxt     = ST_PICK;
            end
          end
          CMD_ADD_SLAVE: ctrl.add = stat.ch_ok;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_TICK: begin
        // advance one channel whenever the output register has room
        if (stat.out_free) begin
          ctrl.tick_step = 1'b1;
          if (stat.tick_last) state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        if (stat.pending_any) begin
          ctrl.spr_pick = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (stat.k_more) begin
          ctrl.spr_read = 1'b1;
          state_nxt     = ST_MARK;
        end else begin
          state_nxt = ST_PICK;
        end
      end
      ST_MARK: begin
        ctrl.spr_mark = 1'b1;
        state_nxt     = ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/mcsl_checker.sv
`timescale 1ns / 1ps
`include "multi_channel_motor_slew_limiter_top_assert.svh"

module mcsl_checker #(
  parameter int NUM_CHANNELS = 10
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_channel,
  input logic signed [7:0] out_drive_level,
  input logic              out_last
);
  localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

  // drive is clamped symmetric, so the most negative code never shows
  `MCSL_ASSERT_IMP(a_drive_range, clk, rst_n, out_valid, out_drive_level != -8'sd128)
  `MCSL_ASSERT_IMP(a_last_on_final, clk, rst_n, out_valid, out_last == (out_channel == LAST_CH))
  `MCSL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `MCSL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(out_drive_level) && $stable(out_last))

endmodule

bind multi_channel_motor_slew_limiter_top mcsl_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mcsl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_channel     (out_ch.out_channel),
  .out_drive_level (out_ch.drive_level),
  .out_last        (out_ch.last)
);
